// ===== rtl/cap_pkg.sv =====
// Shared types, constants and helpers for the collision approach predictor.
`timescale 1ns / 1ps

package cap_pkg;

   // Separation component, held scaled by 20: 20*rel + v*n
   localparam int CompW = 29;
   localparam int MagW  = CompW - 1;
   localparam int ProdW = 2 * MagW;
   localparam int AccW  = ProdW + 2;
   // Running n*g, compared against the reaction limit
   localparam int NgW   = 11;

   localparam logic [AccW-1:0] HitSq      = 58'd16000000;
   localparam logic [AccW-1:0] FarSq      = 58'd40000000000;
   localparam logic [NgW-1:0]  ReactLimit = 11'd990;
   localparam logic [7:0]      GLimitReset = 8'd90;

   // Register index, taken from the word address bit
   localparam logic CsrGLimit = 1'b0;

   typedef struct packed {
      logic [MagW-1:0] a;
      logic [MagW-1:0] b;
   } mul_req_type;

   function automatic logic [MagW-1:0] magnitude(input logic signed [CompW-1:0] v);
      logic [CompW-1:0] u;
      u = v[CompW-1] ? CompW'(-v) : CompW'(v);
      return u[MagW-1:0];
   endfunction

endpackage

// ===== rtl/cap_mul.sv =====
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps

module cap_mul (
   input  logic                        clock,
   input  cap_pkg::mul_req_type        mul_req,
   output logic [cap_pkg::ProdW-1:0]   product_ff
);

   logic [cap_pkg::ProdW-1:0] product_in;

   assign product_in = cap_pkg::ProdW'(mul_req.a) * cap_pkg::ProdW'(mul_req.b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== rtl/cap_csr.sv =====
// Configuration register file: g limit register on an APB-style port.
`timescale 1ns / 1ps

module cap_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [7:0]  g_limit
);

   logic [7:0] g_limit_ff;
   logic [7:0] g_limit_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      g_limit_in = g_limit_ff;
      if (wr_en && csr_paddr[2] == cap_pkg::CsrGLimit) begin
         g_limit_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_limit_ff <= cap_pkg::GLimitReset;
      end else begin
         g_limit_ff <= g_limit_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == cap_pkg::CsrGLimit) ? {24'd0, g_limit_ff} : 32'd0;
   assign g_limit = g_limit_ff;

endmodule

// ===== rtl/collision_approach_predictor.sv =====
// Top level: sequencer that runs the approach search on one shared multiplier.
`timescale 1ns / 1ps
// Sequence: with no aircraft target the sequencer goes from accept straight to DONE; when
// the skip test or the reaction limit ends the check it passes SKIP_MUL and SKIP_CMP, else
// also MX, MY, MZ and ACC for each of k extrapolation steps (k from 1 to MAX_STEPS); DONE
// loads rsp_valid and waits there while the output is stalled. One transaction at a time,
// each step on the shared multiplier; a new one is accepted once the sequencer is in IDLE.
// Reset (synchronous, active high) idles the sequencer, drops rsp_valid, sets g_limit to 90.

module collision_approach_predictor #(
   parameter int MAX_STEPS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_target_is_aircraft,
   input  logic               req_already_avoiding,
   input  logic signed [23:0] req_rel_x,
   input  logic signed [23:0] req_rel_y,
   input  logic signed [23:0] req_rel_z,
   input  logic signed [12:0] req_rel_vx,
   input  logic signed [12:0] req_rel_vy,
   input  logic signed [12:0] req_rel_vz,
   input  logic [23:0]        req_target_range,
   input  logic signed [12:0] req_range_rate,
   input  logic               req_roll_rate_positive,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_collision,
   output logic               rsp_set_track_point,
   output logic               rsp_break_azimuth_negative,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int SW = $clog2(MAX_STEPS + 1);
   localparam int CW = cap_pkg::CompW;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SKIP_MUL = 3'd1;
   localparam logic [2:0] ST_SKIP_CMP = 3'd2;
   localparam logic [2:0] ST_MX       = 3'd3;
   localparam logic [2:0] ST_MY       = 3'd4;
   localparam logic [2:0] ST_MZ       = 3'd5;
   localparam logic [2:0] ST_ACC      = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       hit_ff, hit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_col_ff, rsp_col_in;
   logic       rsp_stp_ff, rsp_stp_in;
   logic       rsp_baz_ff, rsp_baz_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [cap_pkg::NgW-1:0] ng_ff, ng_in;

   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic signed [12:0]   vx_ff, vy_ff, vz_ff;
   logic [23:0]          range_ff;
   logic signed [12:0]   rr_ff;
   logic                 avoid_ff, roll_ff;
   logic [cap_pkg::AccW-1:0] acc_ff, acc_in, past_ff, past_in;

   logic [7:0]                 g_limit;
   cap_pkg::mul_req_type       mul_req;
   logic [cap_pkg::ProdW-1:0]  product;

   logic                       accept;
   logic [cap_pkg::AccW-1:0]   sep_sq;
   logic [32:0]                skip_lhs, skip_rhs;
   logic [12:0]                closing;
   logic                       skip;
   logic                       out_free;
   logic signed [CW-1:0]       px_e, py_e, pz_e;

   cap_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .g_limit    (g_limit)
   );

   cap_mul u_mul (
      .clock     (clock),
      .mul_req   (mul_req),
      .product_ff(product)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   assign px_e = CW'(req_rel_x);
   assign py_e = CW'(req_rel_y);
   assign pz_e = CW'(req_rel_z);

   // Time to impact against reaction time: 2*(range-200)*g > 99*(-rr)
   assign closing  = 13'(-rr_ff);
   assign skip_lhs = {product[31:0], 1'b0};
   assign skip_rhs = 33'(closing) * 33'd99;
   assign skip     = (range_ff > 24'd200) & rr_ff[12] & (skip_lhs > skip_rhs);

   assign sep_sq = acc_ff + cap_pkg::AccW'(product);

   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         ST_SKIP_MUL: begin
            mul_req.a = cap_pkg::MagW'(range_ff - 24'd200);
            mul_req.b = cap_pkg::MagW'(g_limit);
         end
         ST_MX: begin
            mul_req.a = cap_pkg::magnitude(cx_ff);
            mul_req.b = cap_pkg::magnitude(cx_ff);
         end
         ST_MY: begin
            mul_req.a = cap_pkg::magnitude(cy_ff);
            mul_req.b = cap_pkg::magnitude(cy_ff);
         end
         ST_MZ: begin
            mul_req.a = cap_pkg::magnitude(cz_ff);
            mul_req.b = cap_pkg::magnitude(cz_ff);
         end
         default: mul_req = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      steps_in     = steps_ff;
      ng_in        = ng_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      acc_in       = acc_ff;
      past_in      = past_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_col_in   = rsp_col_ff;
      rsp_stp_in   = rsp_stp_ff;
      rsp_baz_in   = rsp_baz_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in   = 1'b0;
               steps_in = '0;
               ng_in    = {3'd0, g_limit};
               past_in  = cap_pkg::FarSq;
               cx_in    = (px_e <<< 4) + (px_e <<< 2) + CW'(req_rel_vx);
               cy_in    = (py_e <<< 4) + (py_e <<< 2) + CW'(req_rel_vy);
               cz_in    = (pz_e <<< 4) + (pz_e <<< 2) + CW'(req_rel_vz);
               state_in = req_target_is_aircraft ? ST_SKIP_MUL : ST_DONE;
            end
         end
         ST_SKIP_MUL: state_in = ST_SKIP_CMP;
         ST_SKIP_CMP: begin
            if (skip || ng_ff >= cap_pkg::ReactLimit) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MX;
            end
         end
         ST_MX: state_in = ST_MY;
         ST_MY: begin
            acc_in   = cap_pkg::AccW'(product);
            state_in = ST_MZ;
         end
         ST_MZ: begin
            acc_in   = sep_sq;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (sep_sq <= cap_pkg::HitSq) begin
               hit_in   = 1'b1;
               state_in = ST_DONE;
            end else if (sep_sq > past_ff) begin
               state_in = ST_DONE;
            end else begin
               // advance one step: n += 2
               past_in  = sep_sq;
               cx_in    = cx_ff + (CW'(vx_ff) <<< 1);
               cy_in    = cy_ff + (CW'(vy_ff) <<< 1);
               cz_in    = cz_ff + (CW'(vz_ff) <<< 1);
               ng_in    = ng_ff + {2'd0, g_limit, 1'b0};
               steps_in = steps_ff + SW'(1);
               if (steps_in < SW'(MAX_STEPS) && ng_in < cap_pkg::ReactLimit) begin
                  state_in = ST_MX;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = hit_ff;
               rsp_stp_in   = hit_ff & ~avoid_ff;
               rsp_baz_in   = hit_ff & ~avoid_ff & roll_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         steps_ff     <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      ng_ff      <= ng_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      acc_ff     <= acc_in;
      past_ff    <= past_in;
      rsp_col_ff <= rsp_col_in;
      rsp_stp_ff <= rsp_stp_in;
      rsp_baz_ff <= rsp_baz_in;
      if (accept) begin
         vx_ff    <= req_rel_vx;
         vy_ff    <= req_rel_vy;
         vz_ff    <= req_rel_vz;
         range_ff <= req_target_range;
         rr_ff    <= req_range_rate;
         avoid_ff <= req_already_avoiding;
         roll_ff  <= req_roll_rate_positive;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_collision              = rsp_col_ff;
   assign rsp_set_track_point        = rsp_stp_ff;
   assign rsp_break_azimuth_negative = rsp_baz_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after a transaction");

   a_track_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stp_ff |-> rsp_col_ff)
      else $error("track point set without collision");

   a_azimuth_needs_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_baz_ff |-> rsp_stp_ff)
      else $error("escape azimuth set without track point");

   a_step_cap: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= SW'(MAX_STEPS))
      else $error("step counter ran past its cap");

   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished check did not reach the output register");
`endif

endmodule
